// ===== hw/rtl/d2i_pkg.sv =====
// ----------------------------------------------------------------------------
// d2i_pkg
// Shared constants and types for the double to integer converter.
// ----------------------------------------------------------------------------
`default_nettype none

package d2i_pkg;

    localparam int unsigned SigBits = 52;
    localparam int unsigned ExpBits = 11;
    localparam logic [ExpBits-1:0] ExpMax = 11'h7FF;
    localparam logic [63:0] Two53M1 = 64'h001F_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NAN   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } t_width;

    // bound magnitude for the given width, signedness and sign
    function automatic logic [63:0] bound_mag(input t_width w, input logic sgn,
                                              input logic neg);
        logic [63:0] b;
        b = 64'd0;
        case (w)
            W8:  b = sgn ? (neg ? 64'd128 : 64'd127) : 64'd255;
            W16: b = sgn ? (neg ? 64'd32768 : 64'd32767) : 64'd65535;
            W32: b = sgn ? (neg ? 64'h8000_0000 : 64'h7FFF_FFFF) : 64'hFFFF_FFFF;
            default: b = Two53M1;
        endcase
        if (!sgn && neg) begin
            b = 64'd0;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/double_to_int_convert.sv =====
// ----------------------------------------------------------------------------
// double_to_int_convert
// One word per cycle while no stall holds the pipe.
// Four register stages: decode, shift, round/bound, select and register out.
// A stall while the output word is valid freezes the whole pipe, bubbles too.
// Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_int_convert
    import d2i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_value_bits,
    input  wire logic [1:0]  i_width_sel,
    input  wire logic        i_is_signed,
    input  wire logic        i_enforce_range,
    input  wire logic        i_clamp_mode,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_result_bits,
    output logic [1:0]       o_status
);

    typedef struct packed {
        logic       neg;
        logic       special;
        logic       is_nan;
        logic       zero;
        t_width     w;
        logic       sgn;
        logic       enf;
        logic       clp;
    } t_ctl;

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // stage 1: decode
    logic [3:0]  r_v;
    t_ctl        r1_c, r2_c, r3_c;
    logic [52:0] r1_sig;
    logic [11:0] r1_ex;     // signed exponent, ex = e - 1075 (-1074 for e = 0)
    logic        r1_left;   // ex >= 0
    logic [6:0]  r1_sh;     // shift amount, saturated at 64

    logic [10:0] e_in;
    logic [51:0] m_in;
    logic [11:0] ex_in;
    logic [11:0] nex_in;
    always_comb begin
        e_in   = i_value_bits[62:52];
        m_in   = i_value_bits[51:0];
        ex_in  = (e_in == 11'd0) ? 12'(-1074) : ({1'b0, e_in} - 12'd1075);
        nex_in = 12'd0 - ex_in;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_c.neg     <= i_value_bits[63];
            r1_c.special <= (e_in == ExpMax);
            r1_c.is_nan  <= (e_in == ExpMax) && (m_in != 52'd0);
            r1_c.zero    <= (e_in == 11'd0) && (m_in == 52'd0);
            r1_c.w       <= t_width'(i_width_sel);
            r1_c.sgn     <= i_is_signed;
            r1_c.enf     <= i_enforce_range;
            r1_c.clp     <= i_clamp_mode;
            r1_sig       <= {(e_in != 11'd0), m_in};
            r1_ex        <= ex_in;
            r1_left      <= !ex_in[11];
            if (!ex_in[11]) begin
                r1_sh <= (ex_in >= 12'd64) ? 7'd64 : ex_in[6:0];
            end else begin
                r1_sh <= (nex_in >= 12'd64) ? 7'd64 : nex_in[6:0];
            end
        end
    end

    // stage 2: shift; keep round bits for right shifts
    logic [63:0] r2_mag;    // truncated magnitude (mod 2^64)
    logic        r2_big;    // ex >= 11
    logic        r2_half;   // first dropped bit
    logic        r2_sticky; // any lower dropped bit
    logic [116:0] wide;
    always_comb begin
        wide = {r1_sig, 64'd0} >> r1_sh;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_c   <= r1_c;
            r2_big <= r1_left && (r1_ex >= 12'd11);
            if (r1_left) begin
                r2_mag    <= (r1_sh == 7'd64) ? 64'd0 : (64'(r1_sig) << r1_sh[5:0]);
                r2_half   <= 1'b0;
                r2_sticky <= 1'b0;
            end else begin
                r2_mag    <= {11'd0, wide[116:64]};
                r2_half   <= wide[63];
                r2_sticky <= (wide[62:0] != 63'd0);
            end
        end
    end

    // stage 3: rounding, bound and range check
    logic [63:0] r3_trunc, r3_rnd, r3_bound;
    logic        r3_big;
    logic        r3_tover;
    logic        inc;
    logic [63:0] bnd;
    always_comb begin
        inc = r2_half && (r2_sticky || r2_mag[0]);
        bnd = bound_mag(r2_c.w, r2_c.sgn, r2_c.neg);
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_c     <= r2_c;
            r3_trunc <= r2_mag;
            r3_rnd   <= r2_mag + 64'(inc);
            r3_bound <= bnd;
            r3_big   <= r2_big;
            r3_tover <= r2_big || (r2_mag > bnd);
        end
    end

    // stage 4: select
    logic [63:0] sel_res;
    logic [1:0]  sel_st;
    logic [63:0] mag, sb;
    always_comb begin
        sel_res = 64'd0;
        sel_st  = ST_OK;
        mag     = 64'd0;
        sb      = 64'd0;
        if (r3_c.enf) begin
            if (r3_c.special) begin
                sel_st = ST_NAN;
            end else if (!r3_c.zero && r3_tover) begin
                sel_st = ST_RANGE;
            end else if (!r3_c.zero) begin
                sel_res = r3_c.neg ? (64'd0 - r3_trunc) : r3_trunc;
            end
        end else if (r3_c.clp && !r3_c.is_nan) begin
            if (r3_c.special || (!r3_c.zero && (r3_big || r3_rnd > r3_bound))) begin
                mag = r3_bound;
            end else if (!r3_c.zero) begin
                mag = r3_rnd;
            end
            sel_res = r3_c.neg ? (64'd0 - mag) : mag;
        end else if (!r3_c.special && !r3_c.zero) begin
            sb = r3_c.neg ? (64'd0 - r3_trunc) : r3_trunc;
            case (r3_c.w)
                W8:  sel_res = r3_c.sgn ? {{56{sb[7]}}, sb[7:0]} : {56'd0, sb[7:0]};
                W16: sel_res = r3_c.sgn ? {{48{sb[15]}}, sb[15:0]} : {48'd0, sb[15:0]};
                W32: sel_res = r3_c.sgn ? {{32{sb[31]}}, sb[31:0]} : {32'd0, sb[31:0]};
                default: sel_res = sb;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_result_bits <= sel_res;
            o_status      <= sel_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end
    assign o_valid = r_v[3];

endmodule

`default_nettype wire

// ===== tb/double_to_int_convert_tb.sv =====
// ----------------------------------------------------------------------------
// double_to_int_convert_tb
// Self-checking bench for the double to integer converter. A queued driver
// sends directed corner words then random words with random gaps; a monitor
// with random stalls compares each output word with a behavioural predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_int_convert_tb
    import d2i_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] value;
        t_width      wsel;
        logic        sgn;
        logic        enf;
        logic        clp;
    } t_conv_in;

    typedef struct packed {
        logic [63:0] bits;
        t_status     status;
    } t_conv_out;

    localparam int WatchdogLimit = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_value_bits;
    logic [1:0]  i_width_sel;
    logic        i_is_signed;
    logic        i_enforce_range;
    logic        i_clamp_mode;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_bits;
    logic [1:0]  o_status;

    t_conv_in  pending_words[$];
    t_conv_out expected_words[$];
    int        errors;
    int        quiet_cycles;
    logic      hold_sender;
    logic      stim_done;
    int        send_gap;
    int        recv_gap;

    double_to_int_convert DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] bound_of(t_width w, logic sgn, logic neg);
        if (!sgn && neg) return 64'd0;
        if (w == W64) return 64'h001F_FFFF_FFFF_FFFF;
        if (sgn) return neg ? (64'd1 << ((8 << w) - 1)) : ((64'd1 << ((8 << w) - 1)) - 1);
        return (64'd1 << (8 << w)) - 1;
    endfunction

    function automatic t_conv_out convert_double(t_conv_in x);
        t_conv_out   r;
        logic        neg, special, is_nan, zero, big;
        logic [10:0] e;
        logic [63:0] sig, mag, bnd, q, rem, half, mask;
        int          ex, w;
        neg     = x.value[63];
        e       = x.value[62:52];
        special = (e == 11'h7FF);
        is_nan  = special && (x.value[51:0] != 0);
        zero    = (x.value[62:0] == 0);
        sig     = (e == 0) ? {12'd0, x.value[51:0]} : {11'd0, 1'b1, x.value[51:0]};
        ex      = (e == 0) ? -1074 : int'(e) - 1075;
        w       = 8 << x.wsel;
        bnd     = bound_of(x.wsel, x.sgn, neg);
        r.bits  = 64'd0;
        r.status = ST_OK;
        big = 1'b0;
        mag = 64'd0;
        if (!special && !zero) begin
            if (ex >= 11) big = 1'b1;
            else if (ex >= 0) mag = sig << ex;
            else if (ex > -64) mag = sig >> (-ex);
        end
        if (x.enf) begin
            if (special) r.status = ST_NAN;
            else if (big || mag > bnd) r.status = ST_RANGE;
            else r.bits = neg ? -mag : mag;
        end else if (x.clp && !is_nan) begin
            if (special) big = 1'b1;
            else if (!zero && ex < 0) begin
                if (ex < -53) mag = 64'd0;
                else begin
                    q    = sig >> (-ex);
                    rem  = sig & ((64'd1 << (-ex)) - 1);
                    half = 64'd1 << (-ex - 1);
                    if (rem > half || (rem == half && q[0])) q = q + 1;
                    mag = q;
                end
            end
            if (big || mag > bnd) mag = bnd;
            r.bits = neg ? -mag : mag;
        end else if (!special && !zero) begin
            if (ex >= 64) mag = 64'd0;
            else if (ex >= 0) mag = sig << ex;
            r.bits = neg ? -mag : mag;
            if (w < 64) begin
                mask = (64'd1 << w) - 1;
                r.bits &= mask;
                if (x.sgn && r.bits[w-1]) r.bits |= ~mask;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: v[62:52] = 11'(11'd1023 + $urandom_range(0, 70) - 10);
            3: v[62:52] = 11'(11'd1023 - $urandom_range(1, 3));
            4: begin
                v[62:52] = 11'(11'd1023 + $urandom_range(0, 60));
                v[30:0] = 31'd0;
                if ($urandom_range(0, 1)) v[51:0] = 52'd0;
            end
            5: v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_word(logic [63:0] v, t_width w, logic s, logic en, logic c);
        t_conv_in x;
        x.value = v;
        x.wsel  = w;
        x.sgn   = s;
        x.enf   = en;
        x.clp   = c;
        pending_words.push_back(x);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_conv_in x;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) expected_words.push_back(convert_double({i_value_bits,
                t_width'(i_width_sel), i_is_signed, i_enforce_range, i_clamp_mode}));
            if (send_gap > 0 || hold_sender || pending_words.size() == 0) begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                x = pending_words.pop_front();
                i_valid         <= 1'b1;
                i_value_bits    <= x.value;
                i_width_sel     <= x.wsel;
                i_is_signed     <= x.sgn;
                i_enforce_range <= x.enf;
                i_clamp_mode    <= x.clp;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_conv_out want;
        int        gap;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word bits=%h status=%0d",
                             $time, o_result_bits, o_status);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_result_bits !== want.bits) begin
                        $display("%0t: result_bits expected %h actual %h",
                                 $time, want.bits, o_result_bits);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        errors++;
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
                recv_gap <= gap;
                i_stall  <= (gap > 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall  <= (recv_gap > 1);
            end else begin
                i_stall  <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] corners[13];
        int          n;
        errors          = 0;
        quiet_cycles    = 0;
        hold_sender     = 1'b0;
        stim_done       = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_value_bits    = 64'd0;
        i_width_sel     = 2'd0;
        i_is_signed     = 1'b0;
        i_enforce_range = 1'b0;
        i_clamp_mode    = 1'b0;
        send_gap        = 0;
        recv_gap        = 0;
        corners = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                    64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                    64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0001,
                    64'h3FE0_0000_0000_0000, 64'hBFF8_0000_0000_0000,
                    64'h4004_0000_0000_0000, 64'h4060_1000_0000_0000,
                    64'hC060_0000_0000_0000, 64'h433F_FFFF_FFFF_FFFF,
                    64'h7FEF_FFFF_FFFF_FFFF};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corners[k])
            queue_word(corners[k], t_width'(k % 4), k[0], k % 3 == 1, k % 3 == 2);
        queue_word(64'hC340_0000_0000_0000, W64, 1'b1, 1'b1, 1'b0);
        queue_word(64'h43E0_0000_0000_0000, W64, 1'b0, 1'b0, 1'b0);
        queue_word(64'h4330_0000_0000_0001, W64, 1'b1, 1'b0, 1'b1);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF, W32, 1'b1, 1'b0, 1'b1);
        queue_word(64'h41EF_FFFF_FFE0_0000, W32, 1'b0, 1'b1, 1'b0);
        wait (pending_words.size() == 0 && !i_valid);
        // hold off until the pipe has drained
        hold_sender <= 1'b1;
        wait (expected_words.size() == 0 && !o_valid);
        @(posedge i_clk);
        hold_sender <= 1'b0;
        for (n = 0; n < 1600; n++)
            queue_word(random_double(), t_width'($urandom_range(0, 3)), 1'($urandom),
                       1'($urandom_range(0, 2) == 0), 1'($urandom));
        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0 && !o_valid) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
